>>> hdl/ati_pkg.sv
// Package for the ANSI text terminal: screen geometry, character codes,
// controller states and the request and result structures.
// No dependencies.
`timescale 1ns / 1ps
package ati_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = COLS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);

  localparam logic [7:0] RESET_ATTR = 8'd15;

  // Character codes the terminal reacts to.
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_HIGH   = 8'h80;
  localparam logic [7:0] FIN_UP    = 8'h41;  // A
  localparam logic [7:0] FIN_DOWN  = 8'h42;  // B
  localparam logic [7:0] FIN_RIGHT = 8'h43;  // C
  localparam logic [7:0] FIN_LEFT  = 8'h44;  // D
  localparam logic [7:0] FIN_POS   = 8'h48;  // H
  localparam logic [7:0] FIN_CLEAR = 8'h4A;  // J
  localparam logic [7:0] FIN_ERASE = 8'h4B;  // K
  localparam logic [7:0] CLEAR_ALL = 8'd2;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PUT,
    ST_COPY,
    ST_COPY_TAIL,
    ST_FILL
  } ctrl_state_t;

  typedef enum logic [1:0] {
    ESC_LEAD,
    ESC_PARAM,
    ESC_FROZEN
  } esc_stage_t;

  typedef struct packed {
    logic              accept;
    logic              op;
    logic [7:0]        char_byte;
    logic [ADDR_W-1:0] cell_index;
  } item_t;

  typedef struct packed {
    logic             done;
    logic [15:0]      cell_data;
    logic [COL_W-1:0] cursor_column;
    logic [ROW_W-1:0] cursor_row;
  } result_t;

endpackage

>>> hdl/ati_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
`timescale 1ns / 1ps
module ati_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/ati_ctrl.sv
// Terminal controller: cursor, escape parser and the sweep engine that
// clears, erases and scrolls the cell memory. Depends on ati_pkg.
`timescale 1ns / 1ps
module ati_ctrl import ati_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  item_t             item,
  input  logic [7:0]        attr,
  output logic              idle,
  output result_t           res,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output logic [15:0]       mem_wdata,
  output logic [ADDR_W-1:0] mem_raddr,
  input  logic [15:0]       mem_rdata
);

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'(CELLS - COLS - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW0 = ADDR_W'(CELLS - COLS);
  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);

  ctrl_state_t       state, state_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic [ADDR_W-1:0] fill_end, fill_end_next;
  logic [15:0]       fill_val, fill_val_next;
  logic              quiet, quiet_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic              esc_active, esc_active_next;
  esc_stage_t        esc_stage, esc_stage_next;
  logic [7:0]        lead, lead_next;
  logic [7:0]        p1, p1_next;
  logic [7:0]        p2, p2_next;
  logic              psel, psel_next;
  logic              op_r;
  logic [7:0]        ch;
  logic [ADDR_W-1:0] idx;

  logic [COL_W:0]    cw;
  logic [ROW_W:0]    rw;
  logic [7:0]        n, r1, c1;
  logic [8:0]        sum;
  logic [11:0]       acc;
  logic              letter;
  logic [ADDR_W-1:0] line_base;
  logic [15:0]       blank;

  assign idle  = (state == ST_IDLE);
  assign blank = {attr, CH_SPACE};

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FILL;
      ptr        <= '0;
      fill_end   <= LAST_CELL;
      fill_val   <= {RESET_ATTR, CH_SPACE};
      quiet      <= 1'b1;
      col        <= '0;
      row        <= '0;
      esc_active <= 1'b0;
      esc_stage  <= ESC_LEAD;
      lead       <= '0;
      p1         <= '0;
      p2         <= '0;
      psel       <= 1'b0;
    end else begin
      state      <= state_next;
      ptr        <= ptr_next;
      fill_end   <= fill_end_next;
      fill_val   <= fill_val_next;
      quiet      <= quiet_next;
      col        <= col_next;
      row        <= row_next;
      esc_active <= esc_active_next;
      esc_stage  <= esc_stage_next;
      lead       <= lead_next;
      p1         <= p1_next;
      p2         <= p2_next;
      psel       <= psel_next;
    end
  end

  // Captured request payload.
  always_ff @(posedge clk) begin
    if (item.accept) begin
      op_r <= item.op;
      ch   <= item.char_byte;
      idx  <= item.cell_index;
    end
  end

  // Next state, memory access and result.
  always_comb begin
    state_next      = state;
    ptr_next        = ptr;
    fill_end_next   = fill_end;
    fill_val_next   = fill_val;
    quiet_next      = quiet;
    col_next        = col;
    row_next        = row;
    esc_active_next = esc_active;
    esc_stage_next  = esc_stage;
    lead_next       = lead;
    p1_next         = p1;
    p2_next         = p2;
    psel_next       = psel;
    mem_we          = 1'b0;
    mem_waddr       = ptr;
    mem_wdata       = fill_val;
    mem_raddr       = ptr + COLS_A;
    res.done        = 1'b0;
    res.cell_data   = '0;
    cw              = {1'b0, col};
    rw              = {1'b0, row};
    n               = (p1 == 8'd0) ? 8'd1 : p1;
    r1              = n - 8'd1;
    c1              = ((p2 == 8'd0) ? 8'd1 : p2) - 8'd1;
    sum             = '0;
    acc             = '0;
    letter          = (ch inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    line_base       = ADDR_W'(row * COLS);

    case (state)
      ST_IDLE: begin
        if (item.accept) begin
          mem_raddr  = item.cell_index;
          state_next = (item.op == OP_READ) ? ST_READ : ST_PUT;
        end
      end

      ST_READ: begin
        res.done      = 1'b1;
        res.cell_data = (idx < LAST_CELL + 1'b1) ? mem_rdata : 16'd0;
        state_next    = ST_IDLE;
      end

      ST_PUT: begin
        res.done   = 1'b1;
        state_next = ST_IDLE;
        if (ch >= CH_HIGH || op_r != OP_PUT) begin
          // High bytes are dropped everywhere.
        end else if (ch == CH_ESC) begin
          esc_active_next = 1'b1;
          esc_stage_next  = ESC_LEAD;
          lead_next       = '0;
          p1_next         = '0;
          p2_next         = '0;
          psel_next       = 1'b0;
        end else if (esc_active) begin
          if (esc_stage == ESC_LEAD) begin
            lead_next = ch;
            if (letter) begin
              esc_active_next = 1'b0;
            end else begin
              esc_stage_next = ESC_PARAM;
            end
          end else if (letter) begin
            esc_active_next = 1'b0;
            if (lead == CH_LBRACK) begin
              case (ch)
                FIN_CLEAR: begin
                  if (p1 == CLEAR_ALL) begin
                    col_next      = '0;
                    row_next      = '0;
                    ptr_next      = '0;
                    fill_end_next = LAST_CELL;
                    fill_val_next = blank;
                    res.done      = 1'b0;
                    state_next    = ST_FILL;
                  end
                end
                FIN_ERASE: begin
                  ptr_next      = line_base + ADDR_W'(col);
                  fill_end_next = line_base + ADDR_W'(COLS - 1);
                  fill_val_next = blank;
                  res.done      = 1'b0;
                  state_next    = ST_FILL;
                end
                FIN_POS: begin
                  row_next = (r1 > 8'(ROWS - 1)) ? ROW_W'(ROWS - 1) : ROW_W'(r1);
                  col_next = (c1 > 8'(COLS - 1)) ? COL_W'(COLS - 1) : COL_W'(c1);
                end
                FIN_UP: begin
                  row_next = (n >= 8'(row)) ? '0 : row - ROW_W'(n);
                end
                FIN_DOWN: begin
                  sum      = {1'b0, n} + 9'(row);
                  row_next = (sum > 9'(ROWS - 1)) ? ROW_W'(ROWS - 1) : ROW_W'(sum);
                end
                FIN_RIGHT: begin
                  sum      = {1'b0, n} + 9'(col);
                  col_next = (sum > 9'(COLS - 1)) ? COL_W'(COLS - 1) : COL_W'(sum);
                end
                FIN_LEFT: begin
                  col_next = (n >= 8'(col)) ? '0 : col - COL_W'(n);
                end
                default: begin
                end
              endcase
            end
          end else if (esc_stage == ESC_PARAM) begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
              // Decimal accumulate, saturating at 255.
              acc = 12'(psel ? p2 : p1) * 12'd10 + 12'(ch - CH_ZERO);
              if (psel) begin
                p2_next = (acc > 12'd255) ? 8'd255 : acc[7:0];
              end else begin
                p1_next = (acc > 12'd255) ? 8'd255 : acc[7:0];
              end
            end else if (ch == CH_SEMI && !psel) begin
              psel_next = 1'b1;
            end else begin
              esc_stage_next = ESC_FROZEN;
            end
          end
        end else begin
          // Plain text and cursor controls.
          if (ch == CH_BS) begin
            if (col != '0) begin
              cw = cw - 1'b1;
            end
          end else if (ch == CH_TAB) begin
            cw = (cw + 2'd2) & ~(COL_W + 1)'(1);
          end else if (ch == CH_CR) begin
            cw = '0;
          end else if (ch == CH_LF) begin
            cw = '0;
            rw = rw + 1'b1;
          end else if (ch >= CH_SPACE) begin
            mem_we    = 1'b1;
            mem_waddr = line_base + ADDR_W'(col);
            mem_wdata = {attr, ch};
            cw        = cw + 1'b1;
          end
          if (cw >= (COL_W + 1)'(COLS)) begin
            cw = '0;
            rw = rw + 1'b1;
          end
          col_next = cw[COL_W-1:0];
          row_next = rw[ROW_W-1:0];
          if (rw >= (ROW_W + 1)'(ROWS)) begin
            row_next      = ROW_W'(ROWS - 1);
            ptr_next      = '0;
            fill_val_next = blank;
            res.done      = 1'b0;
            state_next    = ST_COPY;
          end
        end
      end

      // Scroll: read one line below, write it back in the next cycle.
      ST_COPY: begin
        mem_we    = (ptr != '0);
        mem_waddr = ptr - 1'b1;
        mem_wdata = mem_rdata;
        ptr_next  = ptr + 1'b1;
        if (ptr == LAST_COPY) begin
          state_next = ST_COPY_TAIL;
        end
      end

      ST_COPY_TAIL: begin
        mem_we        = 1'b1;
        mem_waddr     = ptr - 1'b1;
        mem_wdata     = mem_rdata;
        ptr_next      = LAST_ROW0;
        fill_end_next = LAST_CELL;
        state_next    = ST_FILL;
      end

      // Blank fill over a range of cells.
      ST_FILL: begin
        mem_we   = 1'b1;
        ptr_next = ptr + 1'b1;
        if (ptr == fill_end) begin
          res.done   = !quiet;
          quiet_next = 1'b0;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    res.cursor_column = col_next;
    res.cursor_row    = row_next;
  end

endmodule

>>> hdl/ansi_text_terminal_core.sv
// ANSI text terminal, top level: stream ports, attribute register,
// output register, cell memory and controller. Depends on ati_pkg,
// ati_ram and ati_ctrl.
//
// Usage: a request on the s_axis channel either puts one byte into the
// terminal (tuser 0) or reads one screen cell (tuser 1). Every request gives
// exactly one response on m_axis with the cell read (zero for a put) and
// the cursor position after the request. The attribute byte is written
// through cfg_wr_en/cfg_wr_data only while the block is idle; the user
// is bound to this, the block itself does not enforce it. Flow: a read
// or an ordinary put passes through the controller and then the output
// register; the next request can be taken in the cycle the response
// appears if m_axis_tready is high, so requests are taken one at a
// time. The cell memory has one write port, so a scroll copies the
// cells one by one, ESC[2J blanks all 2000 cells and ESC[K the rest of
// the line from the cursor on. Reset: a clearing pass writes blank
// cells with attribute 15 into all 2000 cells; s_axis_tready stays low
// until it is done. Stall: while m_axis_tready is low the response
// holds and no new request is taken.
`timescale 1ns / 1ps
module ansi_text_terminal_core import ati_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] char_byte, [18:8] cell_index
  input  logic        s_axis_tuser,  // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [15:0] cell_data, [22:16] cursor_column,
                                     // [27:23] cursor_row
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic [7:0]        attr;
  item_t             item;
  result_t           res;
  logic              idle;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [15:0]       mem_rdata;
  logic              out_free;

  // Attribute register.
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= RESET_ATTR;
    end else if (cfg_wr_en) begin
      attr <= cfg_wr_data;
    end
  end

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = idle && out_free;

  assign item.accept     = s_axis_tvalid && s_axis_tready;
  assign item.op         = s_axis_tuser;
  assign item.char_byte  = s_axis_tdata[7:0];
  assign item.cell_index = s_axis_tdata[8 +: ADDR_W];

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res.done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      m_axis_tdata <= {4'd0, res.cursor_row, res.cursor_column, res.cell_data};
    end
  end

  ati_ram #(
    .WIDTH (16),
    .DEPTH (1 << ADDR_W)
  ) u_cells (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  ati_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .attr      (attr),
    .idle      (idle),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

>>> hdl/ati_checker.sv
// Port-level checks for the ANSI text terminal, bound to the top level.
// Depends on ansi_text_terminal_core.
`timescale 1ns / 1ps
module ati_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // The clearing pass after reset blocks requests.
  a_reset_busy: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("request taken during clearing pass");

  // One request at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken back to back");

  // A read answers through the controller and the output register.
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |-> ##2 m_axis_tvalid)
    else $error("read response late");

  // The cursor row stays on screen.
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[27:23] <= 5'd24)
    else $error("cursor row off screen");

  // A stalled response holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("response changed while stalled");

endmodule

bind ansi_text_terminal_core ati_checker u_ati_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
